@@ rtl/core/kwtc_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyword transposition cipher package
// Shared constants, codes and types for the keyword transposition cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package kwtc_pkg;

    localparam int MAX_KEY_LEN = 8;
    localparam int KEY_IDX_W   = $clog2(MAX_KEY_LEN);
    localparam int KEY_CNT_W   = $clog2(MAX_KEY_LEN + 1);
    localparam int LETTER_W    = 5;
    localparam int ALPHA       = 26;
    localparam int KEY_W       = MAX_KEY_LEN * LETTER_W;
    localparam int KEY_LEN_W   = 4;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA - 1);
    localparam logic [7:0]          ASCII_A     = 8'd65;
    localparam logic [7:0]          ASCII_Z     = 8'd90;
    localparam logic [7:0]          ASCII_SPACE = 8'd32;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_KEY_LETTERS = 1'b0,
        REG_KEY_LENGTH  = 1'b1
    } cfg_reg_t;

    // Control states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_LOOKUP,
        ST_RESULT
    } kwtc_state_t;

    // States of the alphabet generator.
    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_KEY,
        GEN_OUTER,
        GEN_SCAN
    } gen_state_t;

    // One table write: forward[pos] = letter and inverse[letter] = pos.
    typedef struct packed {
        logic                we;
        logic [LETTER_W-1:0] pos;
        logic [LETTER_W-1:0] letter;
    } tbl_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/kwtc_tables.sv @@
// ----------------------------------------------------------------------------
// Keyword transposition cipher tables
// Forward and inverse substitution memories, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kwtc_tables (
    input  wire logic                              clk,
    input  wire kwtc_pkg::tbl_wr_t                 wr,
    input  wire logic                              rd_en,
    input  wire logic [kwtc_pkg::LETTER_W-1:0]     rd_addr,
    output logic      [kwtc_pkg::LETTER_W-1:0]     fwd_q,
    output logic      [kwtc_pkg::LETTER_W-1:0]     inv_q
);
    import kwtc_pkg::*;

    logic [LETTER_W-1:0] fwd_mem [ALPHA];
    logic [LETTER_W-1:0] inv_mem [ALPHA];

    // Both tables are filled by the same write: the inverse is written at the
    // letter with the position as data.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            fwd_mem[wr.pos]    <= wr.letter;
            inv_mem[wr.letter] <= wr.pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_q <= fwd_mem[rd_addr];
            inv_q <= inv_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/kwtc_alpha_gen.sv @@
// ----------------------------------------------------------------------------
// Keyword transposition cipher alphabet generator
// Emits the mixed alphabet as table writes, one letter at a time in position order.
// ----------------------------------------------------------------------------
`default_nettype none

module kwtc_alpha_gen (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [kwtc_pkg::KEY_W-1:0]         key_letters,
    input  wire logic [kwtc_pkg::KEY_LEN_W-1:0]     key_length,
    output kwtc_pkg::tbl_wr_t                       wr,
    output logic                                    done,
    output logic                                    repeats
);
    import kwtc_pkg::*;

    gen_state_t          gst_reg,   gst_next;
    logic [KEY_CNT_W-1:0] k_reg,    k_next;
    logic [KEY_CNT_W-1:0] ncol_reg, ncol_next;
    logic [ALPHA-1:0]    used_reg,  used_next;
    logic                rep_reg,   rep_next;
    logic [LETTER_W-1:0] i_reg,     i_next;
    logic [LETTER_W-1:0] j_reg,     j_next;
    logic [KEY_IDX_W-1:0] col_reg,  col_next;
    logic [KEY_IDX_W-1:0] rank_reg, rank_next;
    logic [LETTER_W-1:0] pos_reg,   pos_next;
    logic [LETTER_W-1:0] cols_reg [MAX_KEY_LEN];

    logic [LETTER_W-1:0]  klet [MAX_KEY_LEN];
    logic [KEY_CNT_W-1:0] len_eff;
    logic [LETTER_W-1:0]  raw_letter;
    logic [LETTER_W-1:0]  key_letter;
    logic                 col_wr;
    logic [KEY_IDX_W-1:0] col_found;
    logic                 rank_last;
    logic                 emit;
    logic [LETTER_W-1:0]  emit_letter;

    always_comb
    begin
        for (int n = 0; n < MAX_KEY_LEN; n++)
        begin
            klet[n] = key_letters[n*LETTER_W +: LETTER_W];
        end
    end

    // Length zero counts as one letter; longer keys saturate.
    always_comb
    begin
        if (key_length == '0)
        begin
            len_eff = KEY_CNT_W'(1);
        end
        else if (KEY_CNT_W'(key_length) > KEY_CNT_W'(MAX_KEY_LEN))
        begin
            len_eff = KEY_CNT_W'(MAX_KEY_LEN);
        end
        else
        begin
            len_eff = KEY_CNT_W'(key_length);
        end
    end

    assign raw_letter = klet[k_reg[KEY_IDX_W-1:0]];
    assign key_letter = (raw_letter >= LETTER_W'(ALPHA)) ? raw_letter - LETTER_W'(ALPHA)
                                                          : raw_letter;

    // Column of the current outer letter among the distinct key letters kept.
    always_comb
    begin
        col_found = '0;
        for (int n = 0; n < MAX_KEY_LEN; n++)
        begin
            if ((KEY_CNT_W'(n) < ncol_reg) && (cols_reg[n] == i_reg))
            begin
                col_found = KEY_IDX_W'(n);
            end
        end
    end

    assign rank_last = ({1'b0, rank_reg} == (ncol_reg - KEY_CNT_W'(1)));

    always_comb
    begin
        gst_next    = gst_reg;
        k_next      = k_reg;
        ncol_next   = ncol_reg;
        used_next   = used_reg;
        rep_next    = rep_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        col_next    = col_reg;
        rank_next   = rank_reg;
        col_wr      = 1'b0;
        emit        = 1'b0;
        emit_letter = i_reg;
        done        = 1'b0;
        unique case (gst_reg)
            GEN_IDLE:
            begin
                if (start)
                begin
                    gst_next  = GEN_KEY;
                    k_next    = '0;
                    ncol_next = '0;
                    used_next = '0;
                    rep_next  = 1'b0;
                end
            end
            GEN_KEY:
            begin
                if (used_reg[key_letter])
                begin
                    rep_next = 1'b1;
                end
                else
                begin
                    used_next[key_letter] = 1'b1;
                    col_wr    = 1'b1;
                    ncol_next = ncol_reg + KEY_CNT_W'(1);
                end
                k_next = k_reg + KEY_CNT_W'(1);
                if (k_reg == len_eff - KEY_CNT_W'(1))
                begin
                    gst_next = GEN_OUTER;
                    i_next   = '0;
                end
            end
            GEN_OUTER:
            begin
                if (used_reg[i_reg])
                begin
                    emit      = 1'b1;
                    col_next  = col_found;
                    j_next    = '0;
                    rank_next = '0;
                    gst_next  = GEN_SCAN;
                end
                else if (i_reg == LAST_LETTER)
                begin
                    done     = 1'b1;
                    gst_next = GEN_IDLE;
                end
                else
                begin
                    i_next = i_reg + LETTER_W'(1);
                end
            end
            GEN_SCAN:
            begin
                // Walk the leftover letters; those whose rank falls in this
                // column go out in row order.
                if (!used_reg[j_reg])
                begin
                    if (rank_reg == col_reg)
                    begin
                        emit        = 1'b1;
                        emit_letter = j_reg;
                    end
                    rank_next = rank_last ? '0 : rank_reg + KEY_IDX_W'(1);
                end
                if (j_reg == LAST_LETTER)
                begin
                    if (i_reg == LAST_LETTER)
                    begin
                        done     = 1'b1;
                        gst_next = GEN_IDLE;
                    end
                    else
                    begin
                        i_next   = i_reg + LETTER_W'(1);
                        gst_next = GEN_OUTER;
                    end
                end
                else
                begin
                    j_next = j_reg + LETTER_W'(1);
                end
            end
            default:
            begin
                gst_next = GEN_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (gst_reg == GEN_IDLE)
        begin
            pos_next = '0;
        end
        else if (emit)
        begin
            pos_next = pos_reg + LETTER_W'(1);
        end
    end

    assign wr.we     = emit;
    assign wr.pos    = pos_reg;
    assign wr.letter = emit_letter;
    assign repeats   = rep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gst_reg  <= GEN_IDLE;
            k_reg    <= '0;
            ncol_reg <= '0;
            used_reg <= '0;
            rep_reg  <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            col_reg  <= '0;
            rank_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            gst_reg  <= gst_next;
            k_reg    <= k_next;
            ncol_reg <= ncol_next;
            used_reg <= used_next;
            rep_reg  <= rep_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            col_reg  <= col_next;
            rank_reg <= rank_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_wr)
        begin
            cols_reg[ncol_reg[KEY_IDX_W-1:0]] <= key_letter;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/keyword_transposition_cipher.sv @@
// ----------------------------------------------------------------------------
// Keyword transposition cipher
// Substitutes uppercase letters through a keyword-mixed alphabet held in RAM.
// ----------------------------------------------------------------------------
// Result path: with the tables built, an accepted input goes through the table
//   read, then the result load into the output register, which waits while an
//   older result has not been taken.
// Flow: one character at a time, taken only in the idle state, set by the
//   single read port of the substitution memories and the one-item control sequence.
// Table build: the first item after reset or a configuration write first
//   builds the tables by a pass over the key letters, then a walk of the alphabet.
// Reset: asynchronous, active low; the key registers return to letter A with
//   length one, the tables are marked stale and the output is empty.
`default_nettype none

module keyword_transposition_cipher (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [kwtc_pkg::KEY_W-1:0]       cfg_data,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [15:0]                      s_tdata,  // op, char_in[8:1], zeros
    // Result stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [15:0]                      m_tdata   // char_out[7:0], char_bad,
                                                            // key_bad, zeros
);
    import kwtc_pkg::*;

    // Configuration registers.
    logic [KEY_W-1:0]     key_letters_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic                 tables_ready_reg;

    // Control state.
    kwtc_state_t state_reg, state_next;

    // Item held while the tables are built and read.
    logic       op_reg;
    logic [7:0] char_reg;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_bad_reg;
    logic       out_key_bad_reg;

    // Control outputs of the state machine.
    logic s_accept;
    logic gen_start;
    logic rd_en;
    logic out_load;

    // Generator and table interface.
    tbl_wr_t             tbl_wr;
    logic                gen_done;
    logic                gen_repeats;
    logic [LETTER_W-1:0] fwd_q;
    logic [LETTER_W-1:0] inv_q;
    logic [LETTER_W-1:0] rd_addr;
    logic [7:0]          char_diff;

    logic                is_letter;
    logic [LETTER_W-1:0] sub_letter;
    logic [7:0]          res_char;
    logic                res_bad;

    assign s_accept = s_tvalid && s_tready;

    // A configuration write makes the tables stale, so the next item will
    // rebuild them before its lookup. The build ends with the tables valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_letters_reg  <= '0;
            key_length_reg   <= KEY_LEN_W'(1);
            tables_ready_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_KEY_LETTERS: key_letters_reg <= cfg_data;
                    REG_KEY_LENGTH:  key_length_reg  <= cfg_data[KEY_LEN_W-1:0];
                    default:         key_letters_reg <= key_letters_reg;
                endcase
                tables_ready_reg <= 1'b0;
            end
            else if (gen_done)
            begin
                tables_ready_reg <= 1'b1;
            end
        end
    end

    // Next-state logic. Writes to the tables only happen in the build state
    // and reads only afterwards, so no access to one entry ever overlaps.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = tables_ready_reg ? ST_LOOKUP : ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                if (gen_done)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the state machine. The output register decouples the
    // two sides: a new transaction is taken while an older result waits.
    always_comb
    begin
        s_tready  = 1'b0;
        gen_start = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                gen_start = s_tvalid && !tables_ready_reg;
            end
            ST_BUILD:
            begin
                gen_start = 1'b0;
            end
            ST_LOOKUP:
            begin
                rd_en = 1'b1;
            end
            ST_RESULT:
            begin
                out_load = !m_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg   <= s_tdata[0];
            char_reg <= s_tdata[8:1];
        end
    end

    kwtc_alpha_gen u_alpha_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (gen_start),
        .key_letters (key_letters_reg),
        .key_length  (key_length_reg),
        .wr          (tbl_wr),
        .done        (gen_done),
        .repeats     (gen_repeats)
    );

    assign char_diff = char_reg - ASCII_A;
    assign rd_addr   = char_diff[LETTER_W-1:0];
    assign is_letter = (char_reg >= ASCII_A) && (char_reg <= ASCII_Z);

    kwtc_tables u_tables (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (rd_en && is_letter),
        .rd_addr (rd_addr),
        .fwd_q   (fwd_q),
        .inv_q   (inv_q)
    );

    // Letters are substituted; a space passes through, anything else passes
    // through and is flagged.
    assign sub_letter = op_reg ? inv_q : fwd_q;
    assign res_char   = is_letter ? (ASCII_A + {3'b000, sub_letter}) : char_reg;
    assign res_bad    = !is_letter && (char_reg != ASCII_SPACE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg    <= res_char;
            out_bad_reg     <= res_bad;
            out_key_bad_reg <= gen_repeats;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, out_key_bad_reg, out_bad_reg, out_char_reg};

    // The generator only writes the tables while the block is building.
    a_wr_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.we |-> (state_reg == ST_BUILD))
        else $error("table write outside of the build state");

    // The tables become valid only at the end of a build.
    a_ready_from_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tables_ready_reg) |-> $past(gen_done))
        else $error("tables marked valid without a finished build");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten before its transaction");

endmodule

`default_nettype wire
